// ===== hw/rtl/phase_shift_bridge_pwm_defines.svh =====
// Assertion macros shared by the checker of the phase-shift bridge PWM.
// No dependencies; taken in by `include where assertions are written.
`ifndef PHASE_SHIFT_BRIDGE_PWM_DEFINES_SVH
`define PHASE_SHIFT_BRIDGE_PWM_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define PSB_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PSB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/psb_pkg.sv =====
// Shared types, constants and the compare calculation of the phase-shift bridge PWM.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package psb_pkg;

    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;
    localparam int NUM_COMPARES = 5;
    localparam int NUM_LEGS = 4;
    localparam logic [7:0] TIMER_MAX = 8'd255;
    localparam logic [9:0] MIN_WINDOW_MARGIN = 10'd2;

    // Command codes carried in the func field.
    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_SET_PHASE = 3'd1,
        FUNC_START     = 3'd2,
        FUNC_BRAKE     = 3'd3,
        FUNC_CLEAR     = 3'd4
    } func_t;

    // Register indexes (word address bits of the configuration port).
    localparam logic [2:0] REG_PERIOD     = 3'd0;
    localparam logic [2:0] REG_PRIM_DEAD  = 3'd1;
    localparam logic [2:0] REG_RECT_DEAD  = 3'd2;
    localparam logic [2:0] REG_RECT_LEAD  = 3'd3;
    localparam logic [2:0] REG_RECT_TRAIL = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] phase;
        logic        fault_pin_n;
    } psb_in_t;

    typedef struct packed {
        logic        lead_hi;
        logic        lead_lo;
        logic        lag_hi;
        logic        lag_lo;
        logic        rect1_hi;
        logic        rect1_lo;
        logic        rect2_hi;
        logic        rect2_lo;
        logic        faulted;
        logic        running;
        logic        clear_ok;
        logic [15:0] count;
    } psb_out_t;

    typedef struct packed {
        logic [15:0] carrier_period;
        logic [7:0]  primary_dead_ticks;
        logic [7:0]  rectifier_dead_ticks;
        logic [7:0]  rectifier_lead_ticks;
        logic [7:0]  rectifier_trail_ticks;
    } cfg_t;

    typedef logic [NUM_COMPARES-1:0][15:0] cmp_t;

    localparam cfg_t CFG_RESET = '{
        carrier_period:        16'd1600,
        primary_dead_ticks:    8'd16,
        rectifier_dead_ticks:  8'd16,
        rectifier_lead_ticks:  8'd0,
        rectifier_trail_ticks: 8'd0
    };

    // Compare set for a requested phase: B on, B off, SR1 off, SR2 on, SR2 off.
    function automatic cmp_t calc_compares(input logic [15:0] phase, input cfg_t cfg);
        logic [15:0] half;
        logic [15:0] phi;
        logic [9:0]  limit;
        logic [15:0] win;
        cmp_t        cmp;
        half  = {1'b0, cfg.carrier_period[15:1]};
        phi   = (phase > half) ? half : phase;
        limit = 10'(cfg.rectifier_lead_ticks) + 10'(cfg.rectifier_trail_ticks)
              + 10'(cfg.rectifier_dead_ticks) + MIN_WINDOW_MARGIN;
        win   = phi - 16'(cfg.rectifier_trail_ticks);
        cmp[0] = (phi == 16'd0) ? 16'd1 : phi;
        cmp[1] = phi + half;
        if (phi > 16'(limit)) begin
            cmp[2] = win;
            cmp[3] = half + 16'(cfg.rectifier_lead_ticks);
            cmp[4] = half + win;
        end else begin
            // Window too narrow: both rectifier legs are held off.
            cmp[2] = 16'd0;
            cmp[3] = cfg.carrier_period - 16'd1;
            cmp[4] = cfg.carrier_period - 16'd1;
        end
        return cmp;
    endfunction

endpackage

// ===== hw/rtl/psb_regs.sv =====
// Configuration register file of the phase-shift bridge PWM, APB-style port.
// Depends on psb_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module psb_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psb_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [psb_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [psb_pkg::PDATA_BITS-1:0]   prdata,
    output logic                             pready,
    output psb_pkg::cfg_t                    cfg
);

    psb_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign reg_index = paddr[psb_pkg::PADDR_BITS-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= psb_pkg::CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                psb_pkg::REG_PERIOD:     cfg_reg.carrier_period        <= pwdata[15:0];
                psb_pkg::REG_PRIM_DEAD:  cfg_reg.primary_dead_ticks    <= pwdata[7:0];
                psb_pkg::REG_RECT_DEAD:  cfg_reg.rectifier_dead_ticks  <= pwdata[7:0];
                psb_pkg::REG_RECT_LEAD:  cfg_reg.rectifier_lead_ticks  <= pwdata[7:0];
                psb_pkg::REG_RECT_TRAIL: cfg_reg.rectifier_trail_ticks <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            psb_pkg::REG_PERIOD:     prdata = 32'(cfg_reg.carrier_period);
            psb_pkg::REG_PRIM_DEAD:  prdata = 32'(cfg_reg.primary_dead_ticks);
            psb_pkg::REG_RECT_DEAD:  prdata = 32'(cfg_reg.rectifier_dead_ticks);
            psb_pkg::REG_RECT_LEAD:  prdata = 32'(cfg_reg.rectifier_lead_ticks);
            psb_pkg::REG_RECT_TRAIL: prdata = 32'(cfg_reg.rectifier_trail_ticks);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/psb_leg.sv =====
// One bridge leg: raw level register and dead-time counter making the hi and lo gates.
// Depends on psb_pkg for the counter saturation value.
`timescale 1ns / 1ps

module psb_leg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       turn_on,
    input  logic       turn_off,
    input  logic [7:0] dead_ticks,
    input  logic       force_off,
    output logic       gate_hi,
    output logic       gate_lo
);

    logic       level_reg;
    logic       level_next;
    logic [7:0] timer_reg;
    logic [7:0] timer_next;
    logic       settled;

    always_comb begin
        // A turn-off on the same count as a turn-on wins.
        if (turn_off) begin
            level_next = 1'b0;
        end else if (turn_on) begin
            level_next = 1'b1;
        end else begin
            level_next = level_reg;
        end
        if (level_next != level_reg) begin
            timer_next = 8'd0;
        end else if (timer_reg != psb_pkg::TIMER_MAX) begin
            timer_next = timer_reg + 8'd1;
        end else begin
            timer_next = timer_reg;
        end
        settled = timer_next >= dead_ticks;
        gate_hi = level_next && settled && !force_off;
        gate_lo = !level_next && settled && !force_off;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            timer_reg <= 8'd0;
        end else if (step) begin
            level_reg <= level_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// ===== hw/rtl/psb_core.sv =====
// Carrier counter, command handling, shadow and active compares, and the four legs.
// Depends on psb_pkg and instantiates psb_leg.
`timescale 1ns / 1ps

module psb_core #(
    parameter int COUNTER_BITS = psb_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  psb_pkg::psb_in_t  item,
    input  psb_pkg::cfg_t     cfg,
    output psb_pkg::psb_out_t result
);

    localparam int WIDE = ((COUNTER_BITS > 16) ? COUNTER_BITS : 16) + 1;

    logic [COUNTER_BITS-1:0] count_reg;
    logic [COUNTER_BITS-1:0] count_next;
    logic                    run_reg;
    logic                    run_next;
    logic                    stop_reg;
    logic                    stop_next;
    logic                    trip_reg;
    logic                    trip_next;
    psb_pkg::cmp_t           shadow_reg;
    psb_pkg::cmp_t           shadow_next;
    psb_pkg::cmp_t           active_reg;
    psb_pkg::cmp_t           active_next;

    logic [COUNTER_BITS-1:0] count_cmd;
    logic                    run_cmd;
    logic                    stop_cmd;
    logic                    clear_ok;
    logic [WIDE-1:0]         c_wide;
    logic [WIDE-1:0]         c_inc;
    logic [WIDE-1:0]         period_wide;
    logic [WIDE-1:0]         half_wide;
    logic                    at_zero;
    logic [psb_pkg::NUM_LEGS-1:0] leg_on;
    logic [psb_pkg::NUM_LEGS-1:0] leg_off;
    logic [psb_pkg::NUM_LEGS-1:0] gate_hi;
    logic [psb_pkg::NUM_LEGS-1:0] gate_lo;

    // An off compare at or past the period matches at count zero.
    function automatic logic off_match(input logic [WIDE-1:0] c, input logic [15:0] v,
                                       input logic [15:0] period);
        return (c == WIDE'(v)) || ((v >= period) && (c == '0));
    endfunction

    always_comb begin
        trip_next   = trip_reg || !item.fault_pin_n;
        shadow_next = shadow_reg;
        count_cmd   = count_reg;
        run_cmd     = run_reg;
        stop_cmd    = stop_reg;
        clear_ok    = 1'b0;
        unique case (psb_pkg::func_t'(item.func))
            psb_pkg::FUNC_SET_PHASE: begin
                shadow_next = psb_pkg::calc_compares(item.phase, cfg);
            end
            psb_pkg::FUNC_START: begin
                count_cmd = '0;
                run_cmd   = 1'b1;
                stop_cmd  = 1'b0;
            end
            psb_pkg::FUNC_BRAKE: begin
                shadow_next = psb_pkg::calc_compares(16'd0, cfg);
                trip_next   = 1'b1;
                stop_cmd    = 1'b1;
            end
            psb_pkg::FUNC_CLEAR: begin
                if (item.fault_pin_n) begin
                    trip_next = 1'b0;
                    clear_ok  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        c_wide      = WIDE'(count_cmd);
        c_inc       = c_wide + WIDE'(1);
        period_wide = WIDE'(cfg.carrier_period);
        half_wide   = WIDE'(cfg.carrier_period[15:1]);
        at_zero     = (count_cmd == '0);

        active_next = active_reg;
        run_next    = run_cmd;
        stop_next   = stop_cmd;
        count_next  = count_cmd;
        leg_on      = '0;
        leg_off     = '0;
        if (run_cmd) begin
            if (at_zero) begin
                active_next = shadow_next;
            end
            if (at_zero && stop_cmd) begin
                // Brake completes: counter parks at zero, no leg events.
                run_next  = 1'b0;
                stop_next = 1'b0;
            end else begin
                leg_on[0]  = at_zero;
                leg_off[0] = (c_wide == half_wide);
                leg_on[1]  = (c_wide == WIDE'(active_next[0]));
                leg_off[1] = off_match(c_wide, active_next[1], cfg.carrier_period);
                leg_on[2]  = at_zero;
                leg_off[2] = off_match(c_wide, active_next[2], cfg.carrier_period);
                leg_on[3]  = (c_wide == WIDE'(active_next[3]));
                leg_off[3] = off_match(c_wide, active_next[4], cfg.carrier_period);
                if (c_inc >= period_wide) begin
                    count_next = '0;
                end else begin
                    count_next = c_inc[COUNTER_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            run_reg    <= 1'b0;
            stop_reg   <= 1'b0;
            trip_reg   <= 1'b0;
            shadow_reg <= psb_pkg::calc_compares(16'd0, psb_pkg::CFG_RESET);
            active_reg <= psb_pkg::calc_compares(16'd0, psb_pkg::CFG_RESET);
        end else if (step) begin
            count_reg  <= count_next;
            run_reg    <= run_next;
            stop_reg   <= stop_next;
            trip_reg   <= trip_next;
            shadow_reg <= shadow_next;
            active_reg <= active_next;
        end
    end

    for (genvar g = 0; g < psb_pkg::NUM_LEGS; g++) begin : g_leg
        psb_leg u_leg (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .step       (step),
            .turn_on    (leg_on[g]),
            .turn_off   (leg_off[g]),
            .dead_ticks ((g < 2) ? cfg.primary_dead_ticks : cfg.rectifier_dead_ticks),
            .force_off  (trip_next),
            .gate_hi    (gate_hi[g]),
            .gate_lo    (gate_lo[g])
        );
    end

    always_comb begin
        result.lead_hi  = gate_hi[0];
        result.lead_lo  = gate_lo[0];
        result.lag_hi   = gate_hi[1];
        result.lag_lo   = gate_lo[1];
        result.rect1_hi = gate_hi[2];
        result.rect1_lo = gate_lo[2];
        result.rect2_hi = gate_hi[3];
        result.rect2_lo = gate_lo[3];
        result.faulted  = trip_next;
        result.running  = run_next;
        result.clear_ok = clear_ok;
        result.count    = c_wide[15:0];
    end

endmodule

// ===== hw/rtl/phase_shift_bridge_pwm.sv =====
// Top level of the phase-shift bridge PWM: input register, core and result register.
// Depends on psb_pkg, psb_regs and psb_core.
`timescale 1ns / 1ps

// Usage:
// Each item on the s_ channel is one carrier tick carrying a command (tick, set
// phase, start, brake, clear fault), a requested phase and the sampled fault pin.
// Every accepted item gives exactly one result item on the m_ channel with the
// eight gate levels, the fault and run flags, the clear status and the counter
// value that was evaluated for that tick.
// An accepted item is held in the input register, then goes through the core
// into the result register, which drives m_valid. With m_ready held high the
// block takes one item every cycle; the rate is set by the single core stage
// that updates the counter and the leg state once per item.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item, after which s_ready falls until m_ready returns.
// Reset (aresetn low, synchronous) clears both registers, stops the counter, clears the
// trip latch and loads the registers and compares with their phase-zero defaults. The
// user writes configuration through the APB port while idle; the block does not enforce it.
module phase_shift_bridge_pwm #(
    parameter int COUNTER_BITS = psb_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  psb_pkg::psb_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output psb_pkg::psb_out_t               m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psb_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [psb_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [psb_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready
);

    psb_pkg::cfg_t     cfg;
    psb_pkg::psb_in_t  in_data_reg;
    logic              in_valid_reg;
    psb_pkg::psb_out_t out_data_reg;
    logic              out_valid_reg;
    psb_pkg::psb_out_t result;
    logic              advance;

    // The item in the input register moves on once the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    psb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psb_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance || m_ready) begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== hw/rtl/psb_checker.sv =====
// Port-level checker for the phase-shift bridge PWM, bound to the top level.
// Depends on psb_pkg and the assertion macros of phase_shift_bridge_pwm_defines.svh.
`timescale 1ns / 1ps
`include "phase_shift_bridge_pwm_defines.svh"

module psb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input psb_pkg::psb_out_t m_data
);

    logic any_gate;
    logic pair_overlap;

    assign any_gate = m_data.lead_hi || m_data.lead_lo || m_data.lag_hi || m_data.lag_lo
                   || m_data.rect1_hi || m_data.rect1_lo || m_data.rect2_hi
                   || m_data.rect2_lo;
    assign pair_overlap = (m_data.lead_hi && m_data.lead_lo) || (m_data.lag_hi && m_data.lag_lo)
                       || (m_data.rect1_hi && m_data.rect1_lo)
                       || (m_data.rect2_hi && m_data.rect2_lo);

    // A stalled result item stays put until it is taken.
    `PSB_ASSERT_RST(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result item changed while stalled")
    // The trip latch forces every gate low.
    `PSB_ASSERT_RST(a_fault_gates_off, aclk, aresetn, m_valid && m_data.faulted |-> !any_gate, "gate driven while faulted")
    // Dead time keeps the two gates of a leg from conducting together.
    `PSB_ASSERT_RST(a_no_shoot_through, aclk, aresetn, m_valid |-> !pair_overlap, "hi and lo gates of one leg both on")
    // A successful clear leaves the latch open.
    `PSB_ASSERT_RST(a_clear_ok_unlatched, aclk, aresetn, m_valid && m_data.clear_ok |-> !m_data.faulted, "clear reported while still faulted")
    // Reset empties the result register.
    `PSB_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind phase_shift_bridge_pwm psb_checker u_psb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/phase_shift_bridge_pwm_test.sv =====
// Self-checking testbench for phase_shift_bridge_pwm: items are predicted
// in the bench and compared field by field with each result item.
// Depends on psb_pkg and the phase_shift_bridge_pwm RTL only.
`timescale 1ns / 1ps

module phase_shift_bridge_pwm_test;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 4;
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST = 3'd7;

    typedef logic [4:0][15:0] gate_cmp_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    psb_pkg::psb_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    psb_pkg::psb_out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [psb_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [psb_pkg::PDATA_BITS-1:0] pwdata = '0;
    logic [psb_pkg::PDATA_BITS-1:0] prdata;
    logic pready;

    // Bench copy of the gate generator state.
    psb_pkg::cfg_t bridge_cfg;
    logic [15:0] carrier;
    logic run_on;
    logic stop_pending;
    logic tripped;
    gate_cmp_t shadow_cmp;
    gate_cmp_t active_cmp;
    logic [3:0] leg_level;
    logic [3:0][7:0] dead_cnt;

    psb_pkg::psb_out_t gates_due[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned stall_cycles = 0;
    bit gaps_on = 1'b1;
    int unsigned burst_left = 8;
    bit hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_tick = 0;

    phase_shift_bridge_pwm u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Compare set for one phase request: B on, B off, SR1 off, SR2 on, SR2 off.
    function automatic gate_cmp_t phase_compares(input logic [15:0] phase);
        int unsigned half, phi, win, lead, trail, limit;
        gate_cmp_t c;
        half  = bridge_cfg.carrier_period >> 1;
        phi   = (phase > half) ? half : phase;
        lead  = bridge_cfg.rectifier_lead_ticks;
        trail = bridge_cfg.rectifier_trail_ticks;
        limit = lead + trail + bridge_cfg.rectifier_dead_ticks + 2;
        c[0] = (phi != 0) ? 16'(phi) : 16'd1;
        c[1] = 16'(phi + half);
        if (phi > limit) begin
            win  = phi - trail;
            c[2] = 16'(win);
            c[3] = 16'(half + lead);
            c[4] = 16'(half + win);
        end else begin
            c[2] = 16'd0;
            c[3] = 16'(bridge_cfg.carrier_period - 16'd1);
            c[4] = 16'(bridge_cfg.carrier_period - 16'd1);
        end
        return c;
    endfunction

    // An off compare at or beyond the period matches at count zero.
    function automatic logic off_hit(input logic [15:0] c, input logic [15:0] v);
        return (c == v) || (v >= bridge_cfg.carrier_period && c == 16'd0);
    endfunction

    function automatic logic leg_next(input logic cur, input logic on_hit, input logic off);
        return off ? 1'b0 : (on_hit ? 1'b1 : cur);
    endfunction

    task automatic reset_bridge_state();
        bridge_cfg   = psb_pkg::CFG_RESET;
        carrier      = '0;
        run_on       = 1'b0;
        stop_pending = 1'b0;
        tripped      = 1'b0;
        shadow_cmp   = phase_compares(16'd0);
        active_cmp   = shadow_cmp;
        leg_level    = '0;
        dead_cnt     = '0;
    endtask

    // Applies one item to the bench state and returns the gate levels it gives.
    function automatic psb_pkg::psb_out_t next_gate_levels(input psb_pkg::psb_in_t it);
        logic [15:0] cnt;
        logic [3:0] prev;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [7:0] dead;
        logic clr;
        int unsigned half, nxt;
        psb_pkg::psb_out_t r;
        clr = 1'b0;
        if (!it.fault_pin_n) tripped = 1'b1;
        case (it.func)
            psb_pkg::FUNC_SET_PHASE: shadow_cmp = phase_compares(it.phase);
            psb_pkg::FUNC_START: begin
                carrier      = '0;
                run_on       = 1'b1;
                stop_pending = 1'b0;
            end
            psb_pkg::FUNC_BRAKE: begin
                shadow_cmp   = phase_compares(16'd0);
                tripped      = 1'b1;
                stop_pending = 1'b1;
            end
            psb_pkg::FUNC_CLEAR: begin
                if (it.fault_pin_n) begin
                    tripped = 1'b0;
                    clr     = 1'b1;
                end
            end
            default: ;
        endcase
        cnt  = carrier;
        prev = leg_level;
        if (run_on) begin
            if (cnt == 16'd0) active_cmp = shadow_cmp;
            if (cnt == 16'd0 && stop_pending) begin
                run_on       = 1'b0;
                stop_pending = 1'b0;
            end else begin
                half = bridge_cfg.carrier_period >> 1;
                leg_level[0] = leg_next(leg_level[0], cnt == 16'd0, cnt == half);
                leg_level[1] = leg_next(leg_level[1], cnt == active_cmp[0],
                                        off_hit(cnt, active_cmp[1]));
                leg_level[2] = leg_next(leg_level[2], cnt == 16'd0,
                                        off_hit(cnt, active_cmp[2]));
                leg_level[3] = leg_next(leg_level[3], cnt == active_cmp[3],
                                        off_hit(cnt, active_cmp[4]));
                nxt = cnt + 1;
                if (nxt >= bridge_cfg.carrier_period) nxt = 0;
                carrier = 16'(nxt);
            end
        end
        for (int i = 0; i < 4; i++) begin
            dead = (i < 2) ? bridge_cfg.primary_dead_ticks : bridge_cfg.rectifier_dead_ticks;
            if (leg_level[i] != prev[i]) begin
                dead_cnt[i] = 8'd0;
            end else if (dead_cnt[i] != psb_pkg::TIMER_MAX) begin
                dead_cnt[i] = dead_cnt[i] + 8'd1;
            end
            hi[i] = leg_level[i] && dead_cnt[i] >= dead && !tripped;
            lo[i] = !leg_level[i] && dead_cnt[i] >= dead && !tripped;
        end
        r.lead_hi  = hi[0];
        r.lead_lo  = lo[0];
        r.lag_hi   = hi[1];
        r.lag_lo   = lo[1];
        r.rect1_hi = hi[2];
        r.rect1_lo = lo[2];
        r.rect2_hi = hi[3];
        r.rect2_lo = lo[3];
        r.faulted  = tripped;
        r.running  = run_on;
        r.clear_ok = clr;
        r.count    = cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge aclk) begin : check_results
        psb_pkg::psb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (gates_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no item pending",
                                          results_seen));
            end else begin
                want = gates_due.pop_front();
                check_field("lead_hi", m_data.lead_hi, want.lead_hi);
                check_field("lead_lo", m_data.lead_lo, want.lead_lo);
                check_field("lag_hi", m_data.lag_hi, want.lag_hi);
                check_field("lag_lo", m_data.lag_lo, want.lag_lo);
                check_field("rect1_hi", m_data.rect1_hi, want.rect1_hi);
                check_field("rect1_lo", m_data.rect1_lo, want.rect1_lo);
                check_field("rect2_hi", m_data.rect2_hi, want.rect2_hi);
                check_field("rect2_lo", m_data.rect2_lo, want.rect2_lo);
                check_field("faulted", m_data.faulted, want.faulted);
                check_field("running", m_data.running, want.running);
                check_field("clear_ok", m_data.clear_ok, want.clear_ok);
                check_field("count", m_data.count, want.count);
            end
        end
    end

    // The receiver changes its stall pattern now and then; a requested
    // hold-off keeps it stalled for a long stretch while the sender carries on.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 2);
            rx_tick++;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= (rx_tick % 5) >= 2;
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("phase_shift_bridge_pwm_test NOT OK");
            $finish;
        end
    end

    function automatic psb_pkg::psb_in_t make_item(input logic [2:0] op,
                                                   input logic [15:0] phase,
                                                   input logic pin_n);
        psb_pkg::psb_in_t it;
        it.func        = op;
        it.phase       = phase;
        it.fault_pin_n = pin_n;
        return it;
    endfunction

    function automatic psb_pkg::psb_in_t random_item();
        int unsigned roll, half;
        logic [2:0] op;
        logic [15:0] ph;
        roll = $urandom_range(0, 99);
        half = bridge_cfg.carrier_period >> 1;
        ph   = 16'($urandom);
        if (roll < 80) begin
            op = psb_pkg::FUNC_TICK;
        end else if (roll < 88) begin
            op = psb_pkg::FUNC_SET_PHASE;
            if ($urandom_range(0, 3) != 0) ph = 16'($urandom_range(0, half + 3));
        end else if (roll < 91) begin
            op = psb_pkg::FUNC_START;
        end else if (roll < 93) begin
            op = psb_pkg::FUNC_BRAKE;
        end else if (roll < 97) begin
            op = psb_pkg::FUNC_CLEAR;
        end else begin
            op = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
        return make_item(op, ph, $urandom_range(0, 99) != 0);
    endfunction

    // Leaves valid high after acceptance so that back-to-back items need no
    // second assignment in the same step; a gap lowers it at burst ends.
    task automatic send_item(input psb_pkg::psb_in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        gates_due.push_back(next_gate_levels(it));
        if (gaps_on) begin
            if (burst_left != 0) burst_left--;
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(make_item(psb_pkg::FUNC_TICK, 16'($urandom), 1'b1));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (gates_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Writes one register, then reads it back.
    task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want;
        want = '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            psb_pkg::REG_PERIOD: begin
                bridge_cfg.carrier_period = value[15:0];
                want[15:0] = value[15:0];
            end
            psb_pkg::REG_PRIM_DEAD: begin
                bridge_cfg.primary_dead_ticks = value[7:0];
                want[7:0] = value[7:0];
            end
            psb_pkg::REG_RECT_DEAD: begin
                bridge_cfg.rectifier_dead_ticks = value[7:0];
                want[7:0] = value[7:0];
            end
            psb_pkg::REG_RECT_LEAD: begin
                bridge_cfg.rectifier_lead_ticks = value[7:0];
                want[7:0] = value[7:0];
            end
            psb_pkg::REG_RECT_TRAIL: begin
                bridge_cfg.rectifier_trail_ticks = value[7:0];
                want[7:0] = value[7:0];
            end
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read %0h, expected %0h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        // Return to idle before the next transfer may start.
        @(posedge aclk);
    endtask

    task automatic program_all(input int unsigned period, input int unsigned prim_dead,
                               input int unsigned rect_dead, input int unsigned lead,
                               input int unsigned trail);
        program_reg(psb_pkg::REG_PERIOD, period);
        program_reg(psb_pkg::REG_PRIM_DEAD, prim_dead);
        program_reg(psb_pkg::REG_RECT_DEAD, rect_dead);
        program_reg(psb_pkg::REG_RECT_LEAD, lead);
        program_reg(psb_pkg::REG_RECT_TRAIL, trail);
    endtask

    // Every command, the phase clamp, a narrow window, fault, failed and
    // successful clear, brake to a stop at zero, start while tripped.
    task automatic test_directed_commands();
        program_all(8, 1, 0, 0, 1);
        send_item(make_item(psb_pkg::FUNC_TICK, 16'h0000, 1'b1));
        send_item(make_item(FUNC_SPARE_FIRST, 16'hFFFF, 1'b1));
        send_item(make_item(psb_pkg::FUNC_SET_PHASE, 16'd4, 1'b1));
        send_item(make_item(psb_pkg::FUNC_START, 16'h0000, 1'b1));
        send_ticks(8);
        send_item(make_item(psb_pkg::FUNC_SET_PHASE, 16'hFFFF, 1'b1));
        send_ticks(4);
        send_item(make_item(psb_pkg::FUNC_SET_PHASE, 16'd0, 1'b1));
        send_item(make_item(psb_pkg::FUNC_TICK, 16'h5A5A, 1'b0));
        send_item(make_item(psb_pkg::FUNC_CLEAR, 16'h0000, 1'b0));
        send_item(make_item(psb_pkg::FUNC_CLEAR, 16'h0000, 1'b1));
        send_item(make_item(psb_pkg::FUNC_BRAKE, 16'h0000, 1'b1));
        send_ticks(8);
        send_item(make_item(psb_pkg::FUNC_START, 16'h0000, 1'b1));
        send_item(make_item(psb_pkg::FUNC_CLEAR, 16'hA5A5, 1'b1));
        send_item(make_item(FUNC_SPARE_LAST, 16'h0000, 1'b1));
    endtask

    task automatic test_config_extremes();
        wait_drained();
        // Maximum dead time on every leg, long enough for the timers to saturate.
        program_all(600, 255, 255, 0, 0);
        send_item(make_item(psb_pkg::FUNC_CLEAR, 16'h0000, 1'b1));
        send_item(make_item(psb_pkg::FUNC_SET_PHASE, 16'd300, 1'b1));
        send_item(make_item(psb_pkg::FUNC_START, 16'h0000, 1'b1));
        send_ticks(620);
        wait_drained();
        program_all(65535, 0, 0, 255, 255);
        send_item(make_item(psb_pkg::FUNC_SET_PHASE, 16'hFFFF, 1'b1));
        send_item(make_item(psb_pkg::FUNC_START, 16'h0000, 1'b1));
        send_ticks(60);
        wait_drained();
        program_all(4, 0, 0, 0, 0);
        send_item(make_item(psb_pkg::FUNC_SET_PHASE, 16'd2, 1'b1));
        send_item(make_item(psb_pkg::FUNC_START, 16'h0000, 1'b1));
        repeat (40) send_item(random_item());
    endtask

    task automatic test_receiver_hold_off();
        wait_drained();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_item(random_item());
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // Each setting: clear, set a phase and start, then mostly ticks with
    // commands, spare codes and fault pulses mixed in.
    task automatic test_random_operation();
        int unsigned period, roll;
        for (int phase_no = 0; phase_no < 12; phase_no++) begin
            wait_drained();
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
                period = $urandom_range(4, 48);
            end else if (roll < 9) begin
                period = $urandom_range(49, 300);
            end else begin
                period = $urandom_range(301, 2000);
            end
            program_all(period,
                        ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 6),
                        ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 4),
                        $urandom_range(0, 5), $urandom_range(0, 5));
            gaps_on = (phase_no % 3 != 0);
            send_item(make_item(psb_pkg::FUNC_CLEAR, 16'($urandom), 1'b1));
            send_item(make_item(psb_pkg::FUNC_SET_PHASE,
                                16'($urandom_range(0, period / 2)), 1'b1));
            send_item(make_item(psb_pkg::FUNC_START, 16'($urandom), 1'b1));
            repeat (80) send_item(random_item());
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        reset_bridge_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_config_extremes();
        test_receiver_hold_off();
        test_random_operation();
        wait_drained();
        if (mismatches == 0) begin
            $display("phase_shift_bridge_pwm_test OK");
        end else begin
            $display("phase_shift_bridge_pwm_test NOT OK");
        end
        $finish;
    end

endmodule
